>>> rtl/qpdm_pkg.sv
// Shared types, constants and width helpers for the quadrotor PD attitude mixer.
`default_nettype none
package qpdm_pkg;

  // Default fraction width of the fixed-point datapath
  localparam int FRACTION_BITS_DEF = 16;

  // Field widths
  localparam int TRACKER_W = 17;
  localparam int SENSOR_W  = 20;
  localparam int VALUE_W   = 16;
  localparam int MOTOR_W   = 16;
  localparam int DEV_W     = 16;

  // Conversion constants are Q(F+16); rounding drops these 16 extra bits
  localparam int CONV_EXTRA = 16;

  // Constants as fractions of 2^40
  localparam longint K40_TRACKER = 64'sd54975581;       // 1/20000
  localparam longint K40_SENSOR  = 64'sd19190095;       // 0.01745329/1000
  localparam longint K40_RATE    = 64'sd295527472;      // 0.00026878067
  localparam longint K40_KP_TILT = 64'sd796266320835;   // 0.7242
  localparam longint K40_KD_TILT = 64'sd728910238518;   // 0.66294
  localparam longint K40_KP_YAW  = 64'sd5273697571465;  // 4.7964
  localparam longint K40_KD_YAW  = 64'sd4827614708960;  // 4.39069
  localparam longint K40_THRUST  = 64'sd3958241859994;  // magnitude of -3.6

  // Register reset values
  localparam logic [MOTOR_W-1:0] NOMINAL_RESET = MOTOR_W'(72 * 64);
  localparam logic [MOTOR_W-1:0] CMD_MIN_RESET = '0;
  localparam logic [MOTOR_W-1:0] CMD_MAX_RESET = '1;

  typedef enum logic [1:0] {
    REG_USE_TRACKER = 2'd0,
    REG_NOMINAL     = 2'd1,
    REG_CMD_MIN     = 2'd2,
    REG_CMD_MAX     = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    AXIS_THRUST = 2'd0,
    AXIS_ROLL   = 2'd1,
    AXIS_PITCH  = 2'd2,
    AXIS_YAW    = 2'd3
  } axis_e;

  // Post-scaling applied to the shared multiplier's product
  typedef enum logic [1:0] {
    POST_ROUND = 2'd0,  // round half up, Q(F+16) -> Q(F)
    POST_FLOOR = 2'd1,  // floor, Q(2F) -> Q(F)
    POST_EXACT = 2'd2   // integer times Q(F), already Q(F)
  } post_e;

  typedef struct packed {
    logic               use_tracker_angles;
    logic [MOTOR_W-1:0] nominal_speed;
    logic [MOTOR_W-1:0] command_min;
    logic [MOTOR_W-1:0] command_max;
  } cfg_t;

  typedef struct packed {
    logic [MOTOR_W-1:0] motor_one;
    logic [MOTOR_W-1:0] motor_two;
    logic [MOTOR_W-1:0] motor_three;
    logic [MOTOR_W-1:0] motor_four;
    logic               clipped;
  } mix_out_t;

  // Round a 2^-40 constant to the given number of fraction bits
  function automatic longint qk(input longint k40, input int bits);
    return ((((k40 * 2) >>> (40 - bits)) + 1) >>> 1);
  endfunction

  // Measured angle and rate in Q(F), signed
  function automatic int meas_w(input int f);
    return f + 5;
  endfunction

  // Multiplier operand A: samples and measured values
  function automatic int opa_w(input int f);
    return (f + 5 > SENSOR_W) ? f + 5 : SENSOR_W;
  endfunction

  // Multiplier operand B: constants and gains, signed
  function automatic int opb_w(input int f);
    return f + 6;
  endfunction

  // Deviation accumulator in Q(F), signed
  function automatic int acc_w(input int f);
    return f + 21;
  endfunction

endpackage
`default_nettype wire

>>> rtl/qpdm_if.sv
// Valid/ready channel interfaces for axis items and motor command beats.
`default_nettype none
interface qpdm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         axis;
  logic signed [16:0] tracker_angle;
  logic signed [19:0] sensor_angle;
  logic signed [15:0] sensor_rate;
  logic signed [15:0] target_angle;
  logic signed [15:0] target_rate;
  logic signed [15:0] target_accel;

  modport source (
    output valid, axis, tracker_angle, sensor_angle, sensor_rate,
           target_angle, target_rate, target_accel,
    input  ready
  );
  modport sink (
    input  valid, axis, tracker_angle, sensor_angle, sensor_rate,
           target_angle, target_rate, target_accel,
    output ready
  );
endinterface

interface qpdm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] motor_one;
  logic [15:0] motor_two;
  logic [15:0] motor_three;
  logic [15:0] motor_four;
  logic        clipped;

  modport source (
    output valid, motor_one, motor_two, motor_three, motor_four, clipped,
    input  ready
  );
  modport sink (
    input  valid, motor_one, motor_two, motor_three, motor_four, clipped,
    output ready
  );
endinterface
`default_nettype wire

>>> rtl/qpdm_mul.sv
// Shared signed multiplier with rounding, flooring or exact post-scaling.
`default_nettype none
module qpdm_mul #(
  parameter int FRACTION_BITS = qpdm_pkg::FRACTION_BITS_DEF
) (
  input  logic signed [qpdm_pkg::opa_w(FRACTION_BITS)-1:0] a_i,
  input  logic signed [qpdm_pkg::opb_w(FRACTION_BITS)-1:0] b_i,
  input  qpdm_pkg::post_e                                  post_i,
  output logic signed [qpdm_pkg::acc_w(FRACTION_BITS)-1:0] res_o
);

  localparam int OPA_W  = qpdm_pkg::opa_w(FRACTION_BITS);
  localparam int OPB_W  = qpdm_pkg::opb_w(FRACTION_BITS);
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = qpdm_pkg::acc_w(FRACTION_BITS);
  localparam logic signed [PROD_W-1:0] HALF =
    PROD_W'(64'sd1 <<< (qpdm_pkg::CONV_EXTRA - 1));

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rounded;
  logic signed [PROD_W-1:0] floored;

  assign prod    = a_i * b_i;
  assign rounded = (prod + HALF) >>> qpdm_pkg::CONV_EXTRA;
  assign floored = prod >>> FRACTION_BITS;

  always_comb begin
    unique case (post_i)
      qpdm_pkg::POST_ROUND: res_o = ACC_W'(rounded);
      qpdm_pkg::POST_FLOOR: res_o = ACC_W'(floored);
      qpdm_pkg::POST_EXACT: res_o = ACC_W'(prod);
      default:              res_o = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/qpdm_mixer.sv
// Plus-configuration motor mixing with saturation to the command limits.
`default_nettype none
module qpdm_mixer (
  input  qpdm_pkg::cfg_t     cfg_i,
  input  logic signed [15:0] thrust_i,
  input  logic signed [15:0] roll_i,
  input  logic signed [15:0] pitch_i,
  input  logic signed [15:0] yaw_i,
  output qpdm_pkg::mix_out_t mix_o
);

  localparam int MIX_W = 19;

  logic signed [MIX_W-1:0] base;
  logic signed [MIX_W-1:0] lim_hi;
  logic signed [MIX_W-1:0] lim_lo;
  logic signed [MIX_W-1:0] raw [4];
  logic [15:0]             sat [4];
  logic [3:0]              hit;

  assign base   = MIX_W'($signed({1'b0, cfg_i.nominal_speed})) + MIX_W'(thrust_i);
  assign lim_hi = MIX_W'($signed({1'b0, cfg_i.command_max}));
  assign lim_lo = MIX_W'($signed({1'b0, cfg_i.command_min}));

  assign raw[0] = base + MIX_W'(pitch_i) - MIX_W'(yaw_i);
  assign raw[1] = base - MIX_W'(pitch_i) - MIX_W'(yaw_i);
  assign raw[2] = base + MIX_W'(roll_i)  + MIX_W'(yaw_i);
  assign raw[3] = base - MIX_W'(roll_i)  + MIX_W'(yaw_i);

  // Limit to the upper bound first, then raise to the lower bound
  always_comb begin
    logic signed [MIX_W-1:0] v;
    for (int i = 0; i < 4; i++) begin
      v      = raw[i];
      hit[i] = 1'b0;
      if (v > lim_hi) begin
        v      = lim_hi;
        hit[i] = 1'b1;
      end
      if (v < lim_lo) begin
        v      = lim_lo;
        hit[i] = 1'b1;
      end
      sat[i] = v[15:0];
    end
  end

  assign mix_o.motor_one   = sat[0];
  assign mix_o.motor_two   = sat[1];
  assign mix_o.motor_three = sat[2];
  assign mix_o.motor_four  = sat[3];
  assign mix_o.clipped     = |hit;

endmodule
`default_nettype wire

>>> rtl/quadrotor_pd_attitude_mixer.sv
// Top level: PD attitude controller with plus-configuration motor mixing.
`default_nettype none
// A control tick is four beats on the input channel: thrust (axis 0), then
// roll, pitch and yaw (axes 1 to 3). Thrust, roll and pitch beats only update
// the stored deviations; the yaw beat produces one beat on the output channel
// with four saturated motor commands and a clip flag. All arithmetic runs on
// one shared signed multiplier under a small sequencer, so the input is ready
// only while the block is idle. A thrust beat takes the block through accept,
// one multiply and finish. A roll, pitch or yaw beat takes it through accept,
// six multiplier passes (measured angle, measured rate, and for each of the
// angle and rate errors the measured and the commanded part), and a finish
// step. The output is held in a register, so a waiting result
// does not block the next beat; only a yaw beat that finishes while the
// previous result is still untaken holds in its finish cycle until the output
// beat is taken. The fixed-point fraction width is FRACTION_BITS (8 to 24).
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i: 0 selects
// tracker angles, 1 nominal speed, 2 and 3 the lower and upper motor limits.
// Users must write it only while the block is idle; the block does not check.
module quadrotor_pd_attitude_mixer #(
  parameter int FRACTION_BITS = qpdm_pkg::FRACTION_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  qpdm_in_if.sink           in_i,
  qpdm_out_if.source        out_o
);

  localparam int MEAS_W = qpdm_pkg::meas_w(FRACTION_BITS);
  localparam int OPA_W  = qpdm_pkg::opa_w(FRACTION_BITS);
  localparam int OPB_W  = qpdm_pkg::opb_w(FRACTION_BITS);
  localparam int ACC_W  = qpdm_pkg::acc_w(FRACTION_BITS);
  localparam int CONV_B = FRACTION_BITS + qpdm_pkg::CONV_EXTRA;

  localparam logic signed [OPB_W-1:0] K_TRACKER =
    OPB_W'(qpdm_pkg::qk(qpdm_pkg::K40_TRACKER, CONV_B));
  localparam logic signed [OPB_W-1:0] K_SENSOR =
    OPB_W'(qpdm_pkg::qk(qpdm_pkg::K40_SENSOR, CONV_B));
  localparam logic signed [OPB_W-1:0] K_RATE =
    OPB_W'(qpdm_pkg::qk(qpdm_pkg::K40_RATE, CONV_B));
  localparam logic signed [OPB_W-1:0] KP_TILT =
    OPB_W'(qpdm_pkg::qk(qpdm_pkg::K40_KP_TILT, FRACTION_BITS));
  localparam logic signed [OPB_W-1:0] KD_TILT =
    OPB_W'(qpdm_pkg::qk(qpdm_pkg::K40_KD_TILT, FRACTION_BITS));
  localparam logic signed [OPB_W-1:0] KP_YAW =
    OPB_W'(qpdm_pkg::qk(qpdm_pkg::K40_KP_YAW, FRACTION_BITS));
  localparam logic signed [OPB_W-1:0] KD_YAW =
    OPB_W'(qpdm_pkg::qk(qpdm_pkg::K40_KD_YAW, FRACTION_BITS));
  localparam logic signed [OPB_W-1:0] K_THRUST =
    OPB_W'(-qpdm_pkg::qk(qpdm_pkg::K40_THRUST, FRACTION_BITS));
  // Bias that turns the arithmetic shift into truncation toward zero
  localparam logic signed [ACC_W-1:0] TRUNC_BIAS =
    ACC_W'((64'sd1 <<< FRACTION_BITS) - 64'sd1);

  // Sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MEAS = 4'd1;  // measured angle, rounded
  localparam logic [3:0] ST_RATE = 4'd2;  // measured rate, rounded
  localparam logic [3:0] ST_PA   = 4'd3;  // -meas * kp, floored
  localparam logic [3:0] ST_TA   = 4'd4;  // target angle * kp
  localparam logic [3:0] ST_PR   = 4'd5;  // -rate * kd, floored
  localparam logic [3:0] ST_TR   = 4'd6;  // target rate * kd
  localparam logic [3:0] ST_THR  = 4'd7;  // accel * thrust gain
  localparam logic [3:0] ST_FIN  = 4'd8;  // truncate, store or mix

  logic [3:0]          state_q, state_d;
  qpdm_pkg::cfg_t      cfg_q;
  logic signed [15:0]  thrust_q, roll_q, pitch_q;
  logic                out_valid_q;
  qpdm_pkg::mix_out_t  out_q;

  // Captured item
  qpdm_pkg::axis_e     axis_q;
  logic signed [16:0]  tracker_q;
  logic signed [19:0]  sensor_q;
  logic signed [15:0]  srate_q;
  logic signed [15:0]  tangle_q;
  logic signed [15:0]  trate_q;
  logic signed [15:0]  accel_q;

  // Datapath
  logic signed [MEAS_W-1:0] meas_q, rate_q;
  logic signed [MEAS_W-1:0] meas_neg, rate_neg;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_trunc;
  logic signed [15:0]       dev;
  logic signed [OPA_W-1:0]  opa;
  logic signed [OPB_W-1:0]  opb;
  logic signed [OPB_W-1:0]  kp, kd;
  qpdm_pkg::post_e          post;
  logic signed [ACC_W-1:0]  mul_res;
  qpdm_pkg::mix_out_t       mix;

  logic in_fire;
  logic is_yaw;
  logic fin_stall;
  logic fin_emit;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign is_yaw     = (axis_q == qpdm_pkg::AXIS_YAW);
  assign fin_stall  = is_yaw && out_valid_q && !out_o.ready;
  assign fin_emit   = (state_q == ST_FIN) && is_yaw && !fin_stall;

  assign kp       = is_yaw ? KP_YAW : KP_TILT;
  assign kd       = is_yaw ? KD_YAW : KD_TILT;
  assign meas_neg = -meas_q;
  assign rate_neg = -rate_q;

  // Operand selection for the shared multiplier
  always_comb begin
    opa  = '0;
    opb  = '0;
    post = qpdm_pkg::POST_EXACT;
    unique case (state_q)
      ST_MEAS: begin
        post = qpdm_pkg::POST_ROUND;
        if (cfg_q.use_tracker_angles) begin
          opa = OPA_W'(tracker_q);
          opb = K_TRACKER;
        end else begin
          opa = OPA_W'(sensor_q);
          opb = K_SENSOR;
        end
      end
      ST_RATE: begin
        post = qpdm_pkg::POST_ROUND;
        opa  = OPA_W'(srate_q);
        opb  = K_RATE;
      end
      ST_PA: begin
        post = qpdm_pkg::POST_FLOOR;
        opa  = OPA_W'(meas_neg);
        opb  = kp;
      end
      ST_TA: begin
        opa = OPA_W'(tangle_q);
        opb = kp;
      end
      ST_PR: begin
        post = qpdm_pkg::POST_FLOOR;
        opa  = OPA_W'(rate_neg);
        opb  = kd;
      end
      ST_TR: begin
        opa = OPA_W'(trate_q);
        opb = kd;
      end
      ST_THR: begin
        opa = OPA_W'(accel_q);
        opb = K_THRUST;
      end
      default: begin
        opa  = '0;
        opb  = '0;
        post = qpdm_pkg::POST_EXACT;
      end
    endcase
  end

  qpdm_mul #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_mul (
    .a_i    (opa),
    .b_i    (opb),
    .post_i (post),
    .res_o  (mul_res)
  );

  // Truncate the Q(F) deviation toward zero and wrap to 16 bits
  assign acc_trunc = (acc_q + (acc_q[ACC_W-1] ? TRUNC_BIAS : '0)) >>> FRACTION_BITS;
  assign dev       = acc_trunc[15:0];

  qpdm_mixer u_mixer (
    .cfg_i    (cfg_q),
    .thrust_i (thrust_q),
    .roll_i   (roll_q),
    .pitch_i  (pitch_q),
    .yaw_i    (dev),
    .mix_o    (mix)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (qpdm_pkg::axis_e'(in_i.axis) == qpdm_pkg::AXIS_THRUST) ? ST_THR
                                                                           : ST_MEAS;
        end
      end
      ST_MEAS: state_d = ST_RATE;
      ST_RATE: state_d = ST_PA;
      ST_PA:   state_d = ST_TA;
      ST_TA:   state_d = ST_PR;
      ST_PR:   state_d = ST_TR;
      ST_TR:   state_d = ST_FIN;
      ST_THR:  state_d = ST_FIN;
      ST_FIN: begin
        if (!fin_stall) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state, configuration and stored deviations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q                  <= ST_IDLE;
      out_valid_q              <= 1'b0;
      cfg_q.use_tracker_angles <= 1'b0;
      cfg_q.nominal_speed      <= qpdm_pkg::NOMINAL_RESET;
      cfg_q.command_min        <= qpdm_pkg::CMD_MIN_RESET;
      cfg_q.command_max        <= qpdm_pkg::CMD_MAX_RESET;
      thrust_q                 <= '0;
      roll_q                   <= '0;
      pitch_q                  <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (qpdm_pkg::reg_idx_e'(cfg_idx_i))
          qpdm_pkg::REG_USE_TRACKER: cfg_q.use_tracker_angles <= cfg_data_i[0];
          qpdm_pkg::REG_NOMINAL:     cfg_q.nominal_speed      <= cfg_data_i;
          qpdm_pkg::REG_CMD_MIN:     cfg_q.command_min        <= cfg_data_i;
          qpdm_pkg::REG_CMD_MAX:     cfg_q.command_max        <= cfg_data_i;
          default: ;
        endcase
      end

      // Store the finished deviation of a non-emitting axis
      if (state_q == ST_FIN) begin
        unique case (axis_q)
          qpdm_pkg::AXIS_THRUST: thrust_q <= dev;
          qpdm_pkg::AXIS_ROLL:   roll_q   <= dev;
          qpdm_pkg::AXIS_PITCH:  pitch_q  <= dev;
          default: ;
        endcase
      end

      // Hold the result until its beat is taken
      if (fin_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      axis_q    <= qpdm_pkg::axis_e'(in_i.axis);
      tracker_q <= in_i.tracker_angle;
      sensor_q  <= in_i.sensor_angle;
      srate_q   <= in_i.sensor_rate;
      tangle_q  <= in_i.target_angle;
      trate_q   <= in_i.target_rate;
      accel_q   <= in_i.target_accel;
      acc_q     <= '0;
    end

    unique case (state_q)
      ST_MEAS: meas_q <= mul_res[MEAS_W-1:0];
      ST_RATE: rate_q <= mul_res[MEAS_W-1:0];
      ST_PA, ST_TA, ST_PR, ST_TR, ST_THR: acc_q <= acc_q + mul_res;
      default: ;
    endcase

    if (fin_emit) begin
      out_q <= mix;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.motor_one   = out_q.motor_one;
  assign out_o.motor_two   = out_q.motor_two;
  assign out_o.motor_three = out_q.motor_three;
  assign out_o.motor_four  = out_q.motor_four;
  assign out_o.clipped     = out_q.clipped;

endmodule
`default_nettype wire

>>> sim/tb_top.sv
// Testbench for the quadrotor PD attitude mixer: table and random beats against a predictor.
`timescale 1ns / 1ps
module tb_top;
  import qpdm_pkg::*;

  localparam int FRAC            = FRACTION_BITS_DEF;
  localparam int CYCLE_LIMIT     = 400000;
  // Idle time before a register write, so a trailing attitude beat can finish in the block
  localparam int SETTLE_CYCLES   = 24;
  localparam int HOLD_OFF_CYCLES = 500;
  localparam int PHASE_BEATS     = 125;
  localparam int NUM_PHASES      = 6;

  // Round a 2^-40 fraction to the given number of fraction bits, half up
  function automatic longint round_k40(input longint k40, input int bits);
    longint half_step;
    half_step = k40 >>> (39 - bits);
    return (half_step + 1) >>> 1;
  endfunction

  // Conversions are Q(F+16), gains Q(F)
  localparam longint C_TRACKER = round_k40(K40_TRACKER, FRAC + 16);
  localparam longint C_SENSOR  = round_k40(K40_SENSOR, FRAC + 16);
  localparam longint C_RATE    = round_k40(K40_RATE, FRAC + 16);
  localparam longint C_KP_TILT = round_k40(K40_KP_TILT, FRAC);
  localparam longint C_KD_TILT = round_k40(K40_KD_TILT, FRAC);
  localparam longint C_KP_YAW  = round_k40(K40_KP_YAW, FRAC);
  localparam longint C_KD_YAW  = round_k40(K40_KD_YAW, FRAC);
  localparam longint C_THRUST  = -round_k40(K40_THRUST, FRAC);

  typedef struct {
    axis_e              axis;
    logic signed [16:0] tracker_angle;
    logic signed [19:0] sensor_angle;
    logic signed [15:0] sensor_rate;
    logic signed [15:0] target_angle;
    logic signed [15:0] target_rate;
    logic signed [15:0] target_accel;
  } axis_beat_t;

  typedef enum logic [1:0] {
    ROW_BEAT,        // beat checked against the predictor
    ROW_BEAT_KNOWN,  // beat with its motor beat typed into the row
    ROW_WRITE        // register write, issued once the block is idle
  } row_kind_e;

  typedef struct {
    row_kind_e        kind;
    reg_idx_e         idx;
    logic [15:0]      data;
    axis_beat_t       beat;
    mix_out_t         known;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  qpdm_in_if  in_ch ();
  qpdm_out_if out_ch ();

  quadrotor_pd_attitude_mixer #(
    .FRACTION_BITS(FRAC)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state: own copy of the registers and the stored deviations
  logic        use_tracker_m;
  logic [15:0] nominal_m;
  logic [15:0] cmd_min_m;
  logic [15:0] cmd_max_m;
  logic [15:0] thrust_dev_m;
  logic [15:0] roll_dev_m;
  logic [15:0] pitch_dev_m;

  mix_out_t    motor_cmd_q[$];   // motor beats still owed by the block
  stim_row_t   dir_rows[$];
  int          mismatches       = 0;
  int          beats_sent       = 0;
  int          motor_beats_seen = 0;
  int          cycle_count      = 0;
  bit          no_gaps          = 1'b0;
  bit          hold_off_req     = 1'b0;

  // Truncate a Q(F) value toward zero and wrap it to 16 bits
  function automatic logic [15:0] to_int16(input longint d);
    longint q;
    if (d >= 0) q = d >>> FRAC;
    else        q = -((-d) >>> FRAC);
    return q[15:0];
  endfunction

  // PD deviation of one attitude axis, as a wrapped 16-bit integer
  function automatic logic [15:0] pd_deviation(input axis_beat_t b, input longint kp,
                                               input longint kd);
    longint meas, rate, err_angle, err_rate;
    if (use_tracker_m) meas = (longint'(b.tracker_angle) * C_TRACKER + 32768) >>> 16;
    else               meas = (longint'(b.sensor_angle) * C_SENSOR + 32768) >>> 16;
    rate      = (longint'(b.sensor_rate) * C_RATE + 32768) >>> 16;
    err_angle = (longint'(b.target_angle) <<< FRAC) - meas;
    err_rate  = (longint'(b.target_rate) <<< FRAC) - rate;
    // Each product floors back to Q(F); the shift is arithmetic on a signed value
    return to_int16(((err_angle * kp) >>> FRAC) + ((err_rate * kd) >>> FRAC));
  endfunction

  // Clamp one motor command; bit 16 flags a clip. The upper limit goes first,
  // so inverted limits leave the lower one in force.
  function automatic logic [16:0] limit_motor(input int m);
    int  v;
    bit  clip;
    v    = m;
    clip = 1'b0;
    if (v > int'(cmd_max_m)) begin
      v    = int'(cmd_max_m);
      clip = 1'b1;
    end
    if (v < int'(cmd_min_m)) begin
      v    = int'(cmd_min_m);
      clip = 1'b1;
    end
    return {clip, v[15:0]};
  endfunction

  // Advance the predictor by one accepted axis beat
  task automatic predict_mix(input axis_beat_t b, output bit emits, output mix_out_t res);
    int          y, t, r, p, base;
    logic [16:0] l1, l2, l3, l4;
    emits = 1'b0;
    res   = '0;
    case (b.axis)
      AXIS_THRUST: thrust_dev_m = to_int16(longint'(b.target_accel) * C_THRUST);
      AXIS_ROLL:   roll_dev_m   = pd_deviation(b, C_KP_TILT, C_KD_TILT);
      AXIS_PITCH:  pitch_dev_m  = pd_deviation(b, C_KP_TILT, C_KD_TILT);
      default: begin
        y    = int'($signed(pd_deviation(b, C_KP_YAW, C_KD_YAW)));
        t    = int'($signed(thrust_dev_m));
        r    = int'($signed(roll_dev_m));
        p    = int'($signed(pitch_dev_m));
        base = int'(nominal_m) + t;
        // Plus mixing: pitch on motors one and two, roll on three and four
        l1   = limit_motor(base + p - y);
        l2   = limit_motor(base - p - y);
        l3   = limit_motor(base + r + y);
        l4   = limit_motor(base - r + y);
        res.motor_one   = l1[15:0];
        res.motor_two   = l2[15:0];
        res.motor_three = l3[15:0];
        res.motor_four  = l4[15:0];
        res.clipped     = l1[16] | l2[16] | l3[16] | l4[16];
        emits = 1'b1;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  // Gap ahead of a beat: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 82) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Field value of width w: extremes, zero, a band of +-span, or anything
  function automatic longint pick_value(input int w, input int span);
    int     r;
    longint lo, hi;
    lo = -(longint'(1) <<< (w - 1));
    hi = (longint'(1) <<< (w - 1)) - 1;
    r  = $urandom_range(0, 99);
    if (r < 7)  return hi;
    if (r < 14) return lo;
    if (r < 20) return 0;
    if (r < 65) return longint'($urandom_range(0, 2 * span)) - span;
    return lo + longint'($urandom_range(0, (1 << w) - 1));
  endfunction

  function automatic axis_beat_t random_beat(input axis_e a);
    axis_beat_t b;
    b.axis          = a;
    b.tracker_angle = pick_value(17, 20000);
    b.sensor_angle  = pick_value(20, 60000);
    b.sensor_rate   = pick_value(16, 4000);
    b.target_angle  = pick_value(16, 3);
    b.target_rate   = pick_value(16, 3);
    b.target_accel  = pick_value(16, 300);
    return b;
  endfunction

  function automatic stim_row_t beat_row(input axis_e a, input longint tr, input longint sa,
                                         input longint sr, input longint ta, input longint trt,
                                         input longint acc);
    stim_row_t row;
    row.kind               = ROW_BEAT;
    row.idx                = REG_USE_TRACKER;
    row.data               = '0;
    row.known              = '0;
    row.beat.axis          = a;
    row.beat.tracker_angle = tr;
    row.beat.sensor_angle  = sa;
    row.beat.sensor_rate   = sr;
    row.beat.target_angle  = ta;
    row.beat.target_rate   = trt;
    row.beat.target_accel  = acc;
    return row;
  endfunction

  function automatic stim_row_t with_result(input stim_row_t row, input int m1, input int m2,
                                            input int m3, input int m4, input bit clip);
    row.kind              = ROW_BEAT_KNOWN;
    row.known.motor_one   = m1[15:0];
    row.known.motor_two   = m2[15:0];
    row.known.motor_three = m3[15:0];
    row.known.motor_four  = m4[15:0];
    row.known.clipped     = clip;
    return row;
  endfunction

  function automatic stim_row_t write_row(input reg_idx_e idx, input int data);
    stim_row_t row;
    row = beat_row(AXIS_THRUST, 0, 0, 0, 0, 0, 0);
    row.kind = ROW_WRITE;
    row.idx  = idx;
    row.data = data[15:0];
    return row;
  endfunction

  // Offer one beat at the falling edge and hold it until the block takes it.
  // When no gap is drawn, valid stays high straight into the next beat.
  task automatic send_beat(input axis_beat_t b, input bit use_known, input mix_out_t known);
    int       gap;
    bit       emits;
    mix_out_t res;
    gap = pick_gap();
    if (no_gaps) gap = 0;
    repeat (gap) @(negedge clk_i) in_ch.valid <= 1'b0;
    @(negedge clk_i);
    in_ch.valid         <= 1'b1;
    in_ch.axis          <= b.axis;
    in_ch.tracker_angle <= b.tracker_angle;
    in_ch.sensor_angle  <= b.sensor_angle;
    in_ch.sensor_rate   <= b.sensor_rate;
    in_ch.target_angle  <= b.target_angle;
    in_ch.target_rate   <= b.target_rate;
    in_ch.target_accel  <= b.target_accel;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_mix(b, emits, res);
    if (emits) motor_cmd_q.push_back(use_known ? known : res);
    beats_sent++;
  endtask

  // Drop valid, wait for every owed motor beat, then let a trailing
  // thrust, roll or pitch beat finish inside the block
  task automatic settle();
    @(negedge clk_i) in_ch.valid <= 1'b0;
    while (motor_cmd_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i) cfg_we_i <= 1'b0;
    case (idx)
      REG_USE_TRACKER: use_tracker_m = data[0];
      REG_NOMINAL:     nominal_m     = data;
      REG_CMD_MIN:     cmd_min_m     = data;
      default:         cmd_max_m     = data;
    endcase
  endtask

  task automatic configure(input bit tracker, input int nominal, input int lo, input int hi);
    settle();
    write_reg(REG_USE_TRACKER, {15'd0, tracker});
    write_reg(REG_NOMINAL, nominal[15:0]);
    write_reg(REG_CMD_MIN, lo[15:0]);
    write_reg(REG_CMD_MAX, hi[15:0]);
  endtask

  // Check each accepted motor beat against the oldest owed one
  always @(posedge clk_i) begin : check_motor
    mix_out_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      motor_beats_seen++;
      if (motor_cmd_q.size() == 0) begin
        report_mismatch("motor beat with none owed, motor_one", out_ch.motor_one, 0);
      end else begin
        want = motor_cmd_q.pop_front();
        if (out_ch.motor_one !== want.motor_one)
          report_mismatch("motor_one", out_ch.motor_one, want.motor_one);
        if (out_ch.motor_two !== want.motor_two)
          report_mismatch("motor_two", out_ch.motor_two, want.motor_two);
        if (out_ch.motor_three !== want.motor_three)
          report_mismatch("motor_three", out_ch.motor_three, want.motor_three);
        if (out_ch.motor_four !== want.motor_four)
          report_mismatch("motor_four", out_ch.motor_four, want.motor_four);
        if (out_ch.clipped !== want.clipped)
          report_mismatch("clipped", out_ch.clipped, want.clipped);
      end
    end
  end

  // Bound the run; a hung handshake ends here
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d motor beats still owed",
               cycle_count, motor_cmd_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: runs of ready broken by gaps; on request, hold off long enough
  // for the output register and the yaw finish stage to back up into the input
  initial begin : motor_sink
    int run, gap, r;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        @(negedge clk_i) out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      r   = $urandom_range(0, 99);
      run = (r < 5) ? $urandom_range(100, 200) : $urandom_range(1, 30);
      repeat (run) @(negedge clk_i) out_ch.ready <= 1'b1;
      r = $urandom_range(0, 99);
      if (r < 35)      gap = 0;
      else if (r < 80) gap = $urandom_range(1, 3);
      else if (r < 95) gap = $urandom_range(4, 12);
      else             gap = $urandom_range(20, 80);
      repeat (gap) @(negedge clk_i) out_ch.ready <= 1'b0;
    end
  end

  initial begin : stimulus
    int n, nominal, lo, hi;
    // Drive every input to a known value before reset is released
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = REG_USE_TRACKER;
    cfg_data_i          = '0;
    in_ch.valid         = 1'b0;
    in_ch.axis          = AXIS_THRUST;
    in_ch.tracker_angle = '0;
    in_ch.sensor_angle  = '0;
    in_ch.sensor_rate   = '0;
    in_ch.target_angle  = '0;
    in_ch.target_rate   = '0;
    in_ch.target_accel  = '0;
    use_tracker_m = 1'b0;
    nominal_m     = NOMINAL_RESET;
    cmd_min_m     = CMD_MIN_RESET;
    cmd_max_m     = CMD_MAX_RESET;
    thrust_dev_m  = '0;
    roll_dev_m    = '0;
    pitch_dev_m   = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed table. Right after reset all deviations are zero, so a quiet
    // yaw beat gives the hover command on every motor.
    dir_rows.push_back(with_result(beat_row(AXIS_YAW, 0, 0, 0, 0, 0, 0),
                                   4608, 4608, 4608, 4608, 1'b0));
    // Field extremes on every input, with sensor angles selected
    dir_rows.push_back(beat_row(AXIS_THRUST, 65535, 524287, 32767, 32767, 32767, 32767));
    dir_rows.push_back(beat_row(AXIS_ROLL, 65535, 524287, 32767, 32767, 32767, 32767));
    dir_rows.push_back(beat_row(AXIS_PITCH, -65536, -524288, -32768, -32768, -32768, -32768));
    dir_rows.push_back(beat_row(AXIS_YAW, 65535, 524287, 32767, 32767, 32767, 32767));
    dir_rows.push_back(beat_row(AXIS_THRUST, -65536, -524288, -32768, -32768, -32768, -32768));
    dir_rows.push_back(beat_row(AXIS_ROLL, -65536, -524288, -32768, -32768, -32768, -32768));
    dir_rows.push_back(beat_row(AXIS_YAW, -65536, -524288, -32768, -32768, -32768, -32768));
    // Tracker angles; repeated roll overwrites, missing thrust keeps its deviation
    dir_rows.push_back(write_row(REG_USE_TRACKER, 1));
    dir_rows.push_back(beat_row(AXIS_ROLL, -65536, 524287, 100, 32767, -1, 5));
    dir_rows.push_back(beat_row(AXIS_PITCH, 65535, -524288, -100, -1, 1, -5));
    dir_rows.push_back(beat_row(AXIS_ROLL, 20000, 0, 0, 1, 0, 0));
    dir_rows.push_back(beat_row(AXIS_YAW, -65536, 0, -32768, 2, -2, 0));
    // Inverted limits: the lower limit wins on every motor and clip is raised
    dir_rows.push_back(write_row(REG_CMD_MIN, 40000));
    dir_rows.push_back(write_row(REG_CMD_MAX, 1000));
    dir_rows.push_back(with_result(beat_row(AXIS_YAW, 0, 0, 0, 0, 0, 0),
                                   40000, 40000, 40000, 40000, 1'b1));
    // Limits pinned at zero, then the widest range at the top nominal speed
    dir_rows.push_back(write_row(REG_CMD_MIN, 0));
    dir_rows.push_back(write_row(REG_CMD_MAX, 0));
    dir_rows.push_back(beat_row(AXIS_YAW, 3, 7, 9, 0, 0, 0));
    dir_rows.push_back(write_row(REG_CMD_MAX, 65535));
    dir_rows.push_back(write_row(REG_NOMINAL, 65535));
    dir_rows.push_back(beat_row(AXIS_THRUST, 0, 0, 0, 0, 0, -3));
    dir_rows.push_back(beat_row(AXIS_YAW, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(write_row(REG_NOMINAL, 0));
    dir_rows.push_back(beat_row(AXIS_YAW, 1, -1, 1, 0, 0, 0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        settle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_beat(dir_rows[i].beat, dir_rows[i].kind == ROW_BEAT_KNOWN, dir_rows[i].known);
      end
    end

    // Random phases, one register setting each
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      nominal = $urandom_range(0, 65535);
      case (phase)
        0: configure(1'b0, NOMINAL_RESET, CMD_MIN_RESET, CMD_MAX_RESET);
        1: configure(1'b1, nominal, $urandom_range(0, 30000), $urandom_range(35000, 65535));
        2: begin
          // Narrow window around hover so clipping is frequent
          lo = (nominal > 300) ? nominal - $urandom_range(0, 300) : 0;
          hi = (nominal < 65235) ? nominal + $urandom_range(0, 300) : 65535;
          configure(1'b0, nominal, lo, hi);
        end
        3: configure(1'b1, 0, 0, 65535);
        4: configure(1'b0, 65535, 0, 65535);
        default: configure($urandom_range(0, 1), nominal, $urandom_range(0, 65535),
                           $urandom_range(0, 65535));
      endcase
      hold_off_req = (phase == 2);
      no_gaps      = (phase == 3);
      n = 0;
      while (n < PHASE_BEATS) begin
        if ($urandom_range(0, 99) < 80) begin
          // Well-formed tick: thrust, roll, pitch, yaw
          for (int a = 0; a < 4; a++) send_beat(random_beat(axis_e'(a)), 1'b0, '0);
          n += 4;
        end else begin
          send_beat(random_beat(axis_e'($urandom_range(0, 3))), 1'b0, '0);
          n += 1;
        end
      end
      no_gaps = 1'b0;
    end

    settle();
    $display("Covered %0d axis beats and %0d motor beats over %0d register settings,",
             beats_sent, motor_beats_seen, NUM_PHASES + 5);
    $display("including inverted and pinned limits and a %0d-cycle output hold-off; %0d mismatches",
             HOLD_OFF_CYCLES, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
